@@ sv/pfa_pkg.sv @@
// Shared types, codes and constants of the paged element allocator.
package pfa_pkg;

    localparam int ADDR_W      = 64;
    localparam int ESZ_W       = 16;
    localparam int SHIFT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int DW          = 21;
    localparam int DCW         = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd20;
    localparam logic [ESZ_W-1:0]   ELEM_MIN  = 16'd4;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPAGE  = 2'd1;
    localparam logic [1:0] ST_NOEMPTY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT = 2'd1;

    typedef enum logic [5:0] {
        S_IDLE,
        S_AL_HEAD,
        S_AL_DIV,
        S_AL_CAP,
        S_AL_POOL,
        S_AL_SETUP,
        S_SERVE,
        S_LINK,
        S_USED,
        S_MUL,
        S_ADDR,
        S_FR_SUB,
        S_FR_PAGE,
        S_FR_CHK0,
        S_FR_DIV,
        S_FR_CHK,
        S_FR_UPD,
        S_FR_EMPTY,
        S_RL_HEAD,
        S_RL_POOL,
        S_RL_ADDR,
        S_RM_RD,
        S_RM_PV,
        S_RM_NX,
        S_RM_CLR,
        S_IN_HEAD,
        S_IN_RD,
        S_IN_P,
        S_IN_H,
        S_IN_N,
        S_FAIL,
        S_DONE
    } state_t;

    typedef struct packed {
        state_t step;
        logic   accept;
        logic   load;
    } cmd_t;

    typedef struct packed {
        logic head_nil;
        logic div_busy;
        logic cap_zero;
        logic bump_left;
        logic chain_ok;
        logic bump_ok;
        logic now_full;
        logic out_range;
        logic page_idle;
        logic idx_bad;
        logic last_elem;
        logic was_full;
    } sts_t;

endpackage

@@ sv/pfa_req_if.sv @@
// Request channel: one allocator operation per transaction.
interface pfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  size_class;
    logic [15:0] elem_size;
    logic [63:0] address;

    modport source (output valid, output operation, output size_class, output elem_size,
                    output address, input ready);
    modport sink (input valid, input operation, input size_class, input elem_size,
                  input address, output ready);
endinterface

@@ sv/pfa_rsp_if.sv @@
// Response channel: one result per transaction.
interface pfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_address;
    logic [1:0]  status;

    modport source (output valid, output result_address, output status, input ready);
    modport sink (input valid, input result_address, input status, output ready);
endinterface

@@ sv/pfa_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
module pfa_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pfa_pkg::DW-1:0]        dividend,
    input  logic [pfa_pkg::ESZ_W-1:0]     divisor,
    output logic                          busy,
    output logic [pfa_pkg::DW-1:0]        quotient
);

    logic [pfa_pkg::ESZ_W-1:0] rem_reg;
    logic [pfa_pkg::ESZ_W-1:0] rem_next;
    logic [pfa_pkg::DW-1:0]    quo_reg;
    logic [pfa_pkg::DW-1:0]    quo_next;
    logic [pfa_pkg::ESZ_W-1:0] dsr_reg;
    logic [pfa_pkg::DCW-1:0]   cnt_reg;
    logic [pfa_pkg::DCW-1:0]   cnt_next;
    logic [pfa_pkg::ESZ_W:0]   trial;
    logic [pfa_pkg::ESZ_W:0]   diff;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[pfa_pkg::DW-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[pfa_pkg::ESZ_W-1:0];
                quo_next = {quo_reg[pfa_pkg::DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[pfa_pkg::ESZ_W-1:0];
                quo_next = {quo_reg[pfa_pkg::DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= pfa_pkg::DCW'(pfa_pkg::DW);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

@@ sv/pfa_datapath.sv @@
// Datapath: page table, list heads, element links, divider and address arithmetic.
module pfa_datapath
#(
    parameter int PAGES          = 16,
    parameter int ELEMS_PER_PAGE = 256,
    parameter int SIZE_CLASSES   = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::ADDR_W-1:0]       cfg_data,
    input  logic [1:0]                       operation,
    input  logic [1:0]                       size_class,
    input  logic [pfa_pkg::ESZ_W-1:0]        elem_size,
    input  logic [pfa_pkg::ADDR_W-1:0]       address,
    input  pfa_pkg::cmd_t                    cmd,
    output pfa_pkg::sts_t                    sts,
    output logic [pfa_pkg::ADDR_W-1:0]       result_address,
    output logic [1:0]                       status
);

    localparam int PW    = $clog2(PAGES);
    localparam int PIW   = $clog2(PAGES + 1);
    localparam int EW    = $clog2(ELEMS_PER_PAGE + 1);
    localparam int AW    = $clog2(PAGES * ELEMS_PER_PAGE);
    localparam int LISTS = SIZE_CLASSES + 2;
    localparam int LW    = $clog2(LISTS);
    localparam int PRODW = EW + pfa_pkg::ESZ_W;

    localparam logic [PIW-1:0] PNIL       = '1;
    localparam logic [EW-1:0]  ENIL       = '1;
    localparam logic [PIW-1:0] PAGES_C    = PIW'(PAGES);
    localparam logic [EW-1:0]  ELEMS_C    = EW'(ELEMS_PER_PAGE);
    localparam logic [LW-1:0]  LIST_EMPTY = LW'(SIZE_CLASSES);
    localparam logic [LW-1:0]  LIST_POOL  = LW'(SIZE_CLASSES + 1);

    logic [EW-1:0]            chain_a [PAGES];
    logic [EW-1:0]            bump_a  [PAGES];
    logic [EW-1:0]            used_a  [PAGES];
    logic [EW-1:0]            cap_a   [PAGES];
    logic [pfa_pkg::ESZ_W-1:0] esz_a  [PAGES];
    logic [PIW-1:0]           prev_a  [PAGES];
    logic [PIW-1:0]           next_a  [PAGES];
    logic [PIW-1:0]           lh_a    [LISTS];
    logic [EW-1:0]            link_mem [PAGES * ELEMS_PER_PAGE];

    logic [pfa_pkg::ADDR_W-1:0]  base_reg;
    logic [pfa_pkg::SHIFT_W-1:0] shift_reg;
    logic [LW-1:0]               cls_reg;
    logic [LW-1:0]               li_reg;
    logic [pfa_pkg::ESZ_W-1:0]   esz_reg;
    logic [pfa_pkg::ADDR_W-1:0]  off_reg;
    logic [PIW-1:0]              p_reg;
    logic [PIW-1:0]              pv_reg;
    logic [PIW-1:0]              nx_reg;
    logic [PIW-1:0]              bumped_reg;
    logic [EW-1:0]               idx_reg;
    logic [EW-1:0]               cap_reg;
    logic [EW-1:0]               link_q;
    logic [PRODW-1:0]            prod_reg;
    logic [pfa_pkg::ADDR_W-1:0]  res_reg;
    logic [1:0]                  st_reg;
    logic [pfa_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [1:0]                  out_st_reg;

    logic [pfa_pkg::SHIFT_W-1:0] s_eff;
    logic [LW-1:0]               cls_in;
    logic [PW-1:0]               pa;
    logic [EW-1:0]               r_chain;
    logic [EW-1:0]               r_bump;
    logic [EW-1:0]               r_used;
    logic [EW-1:0]               r_cap;
    logic [pfa_pkg::ESZ_W-1:0]   r_esz;
    logic [PIW-1:0]              r_prev;
    logic [PIW-1:0]              r_next;
    logic [PIW-1:0]              lh_cur;
    logic [pfa_pkg::ADDR_W-1:0]  pg64;
    logic [pfa_pkg::ADDR_W-1:0]  page_base;
    logic [AW-1:0]               link_base;
    logic                        div_start;
    logic [pfa_pkg::DW-1:0]      div_dividend;
    logic [pfa_pkg::ESZ_W-1:0]   div_divisor;
    logic                        div_busy;
    logic [pfa_pkg::DW-1:0]      quot;

    always_comb
    begin
        if (shift_reg < pfa_pkg::SHIFT_MIN)
        begin
            s_eff = pfa_pkg::SHIFT_MIN;
        end
        else if (shift_reg > pfa_pkg::SHIFT_MAX)
        begin
            s_eff = pfa_pkg::SHIFT_MAX;
        end
        else
        begin
            s_eff = shift_reg;
        end
    end

    always_comb
    begin
        if (SIZE_CLASSES == 1)
        begin
            cls_in = '0;
        end
        else if (LW'(size_class) >= LW'(SIZE_CLASSES))
        begin
            cls_in = LW'(size_class) - LW'(SIZE_CLASSES);
        end
        else
        begin
            cls_in = LW'(size_class);
        end
    end

    always_comb
    begin
        case (cmd.step)
            pfa_pkg::S_RM_PV, pfa_pkg::S_IN_RD, pfa_pkg::S_IN_H: pa = pv_reg[PW-1:0];
            pfa_pkg::S_RM_NX, pfa_pkg::S_IN_N:                   pa = nx_reg[PW-1:0];
            default:                                             pa = p_reg[PW-1:0];
        endcase
    end

    assign r_chain   = chain_a[pa];
    assign r_bump    = bump_a[pa];
    assign r_used    = used_a[pa];
    assign r_cap     = cap_a[pa];
    assign r_esz     = esz_a[pa];
    assign r_prev    = prev_a[pa];
    assign r_next    = next_a[pa];
    assign lh_cur    = lh_a[li_reg];
    assign pg64      = off_reg >> s_eff;
    assign page_base = base_reg + (pfa_pkg::ADDR_W'(p_reg) << s_eff);
    assign link_base = AW'(p_reg[PW-1:0]) * AW'(ELEMS_PER_PAGE);

    assign div_start    = ((cmd.step == pfa_pkg::S_AL_HEAD) && sts.head_nil) ||
                          ((cmd.step == pfa_pkg::S_FR_CHK0) && !sts.page_idle);
    assign div_dividend = (cmd.step == pfa_pkg::S_AL_HEAD) ?
                          (pfa_pkg::DW'(1) << s_eff) : off_reg[pfa_pkg::DW-1:0];
    assign div_divisor  = (cmd.step == pfa_pkg::S_AL_HEAD) ? esz_reg : r_esz;

    pfa_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_comb
    begin
        sts.head_nil  = (lh_cur >= PAGES_C);
        sts.div_busy  = div_busy;
        sts.cap_zero  = (quot == '0);
        sts.bump_left = (bumped_reg < PAGES_C);
        sts.chain_ok  = (r_chain < r_cap);
        sts.bump_ok   = (r_bump < r_cap);
        sts.now_full  = ({1'b0, r_used} + 1'b1) >= {1'b0, r_cap};
        sts.out_range = (pg64 >= pfa_pkg::ADDR_W'(PAGES));
        sts.page_idle = (r_used == '0) || (r_esz == '0);
        sts.idx_bad   = (quot >= pfa_pkg::DW'(r_bump)) ||
                        (quot >= pfa_pkg::DW'(ELEMS_PER_PAGE));
        sts.last_elem = (r_used == EW'(1));
        sts.was_full  = (r_used >= r_cap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            shift_reg <= 5'd12;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pfa_pkg::CFG_BASE)
            begin
                base_reg <= cfg_data;
            end
            else if (cfg_index == pfa_pkg::CFG_SHIFT)
            begin
                shift_reg <= cfg_data[pfa_pkg::SHIFT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGES; i++)
            begin
                chain_a[i] <= ENIL;
                bump_a[i]  <= '0;
                used_a[i]  <= '0;
                cap_a[i]   <= '0;
                esz_a[i]   <= '0;
                prev_a[i]  <= PNIL;
                next_a[i]  <= PNIL;
            end
        end
        else
        begin
            case (cmd.step)
                pfa_pkg::S_AL_SETUP:
                begin
                    chain_a[pa] <= ENIL;
                    bump_a[pa]  <= '0;
                    used_a[pa]  <= '0;
                    cap_a[pa]   <= cap_reg;
                    esz_a[pa]   <= esz_reg;
                end
                pfa_pkg::S_SERVE:
                begin
                    if (!sts.chain_ok && sts.bump_ok)
                    begin
                        bump_a[pa] <= r_bump + 1'b1;
                    end
                end
                pfa_pkg::S_LINK:
                begin
                    chain_a[pa] <= (link_q < ELEMS_C) ? link_q : ENIL;
                end
                pfa_pkg::S_USED:
                begin
                    used_a[pa] <= r_used + 1'b1;
                end
                pfa_pkg::S_FR_UPD:
                begin
                    chain_a[pa] <= idx_reg;
                    used_a[pa]  <= r_used - 1'b1;
                end
                pfa_pkg::S_RM_PV:
                begin
                    if (pv_reg < PAGES_C)
                    begin
                        next_a[pa] <= nx_reg;
                    end
                end
                pfa_pkg::S_RM_NX:
                begin
                    if (nx_reg < PAGES_C)
                    begin
                        prev_a[pa] <= pv_reg;
                    end
                end
                pfa_pkg::S_RM_CLR:
                begin
                    prev_a[pa] <= PNIL;
                    next_a[pa] <= PNIL;
                end
                pfa_pkg::S_IN_HEAD:
                begin
                    if (sts.head_nil)
                    begin
                        prev_a[pa] <= p_reg;
                        next_a[pa] <= p_reg;
                    end
                end
                pfa_pkg::S_IN_P:
                begin
                    prev_a[pa] <= pv_reg;
                    next_a[pa] <= nx_reg;
                end
                pfa_pkg::S_IN_H:
                begin
                    next_a[pa] <= p_reg;
                end
                pfa_pkg::S_IN_N:
                begin
                    prev_a[pa] <= p_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LISTS; i++)
            begin
                lh_a[i] <= PNIL;
            end
        end
        else if (cmd.step == pfa_pkg::S_RM_CLR)
        begin
            if (lh_cur == p_reg)
            begin
                lh_a[li_reg] <= ((nx_reg == p_reg) || (nx_reg >= PAGES_C)) ? PNIL : nx_reg;
            end
        end
        else if ((cmd.step == pfa_pkg::S_IN_HEAD) && sts.head_nil)
        begin
            lh_a[li_reg] <= p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step == pfa_pkg::S_FR_UPD)
        begin
            link_mem[link_base + AW'(idx_reg)] <= r_chain;
        end
        if (cmd.step == pfa_pkg::S_SERVE)
        begin
            link_q <= link_mem[link_base + AW'(r_chain)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bumped_reg <= '0;
            li_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                li_reg <= (operation == pfa_pkg::OP_RELEASE) ? LIST_EMPTY : cls_in;
            end
            else
            begin
                case (cmd.step)
                    pfa_pkg::S_AL_CAP, pfa_pkg::S_RL_POOL: li_reg <= LIST_POOL;
                    pfa_pkg::S_AL_SETUP:                   li_reg <= cls_reg;
                    pfa_pkg::S_FR_EMPTY:                   li_reg <= LIST_EMPTY;
                    pfa_pkg::S_FR_UPD:
                    begin
                        if (sts.last_elem && sts.was_full)
                        begin
                            li_reg <= LIST_EMPTY;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if ((cmd.step == pfa_pkg::S_AL_POOL) && !sts.head_nil == 1'b0 && sts.bump_left)
            begin
                bumped_reg <= bumped_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cls_reg <= cls_in;
            esz_reg <= (elem_size < pfa_pkg::ELEM_MIN) ? pfa_pkg::ELEM_MIN : elem_size;
            off_reg <= address;
            res_reg <= '0;
            st_reg  <= pfa_pkg::ST_OK;
        end
        else
        begin
            case (cmd.step)
                pfa_pkg::S_AL_HEAD:
                begin
                    p_reg <= lh_cur;
                end
                pfa_pkg::S_AL_CAP:
                begin
                    cap_reg <= (quot > pfa_pkg::DW'(ELEMS_PER_PAGE)) ? ELEMS_C : EW'(quot);
                end
                pfa_pkg::S_AL_POOL:
                begin
                    p_reg <= sts.head_nil ? bumped_reg : lh_cur;
                end
                pfa_pkg::S_SERVE:
                begin
                    idx_reg <= sts.chain_ok ? r_chain : r_bump;
                end
                pfa_pkg::S_MUL:
                begin
                    prod_reg <= PRODW'(idx_reg) * PRODW'(r_esz);
                    res_reg  <= page_base;
                end
                pfa_pkg::S_ADDR:
                begin
                    res_reg <= res_reg + pfa_pkg::ADDR_W'(prod_reg);
                end
                pfa_pkg::S_FR_SUB:
                begin
                    off_reg <= off_reg - base_reg;
                end
                pfa_pkg::S_FR_PAGE:
                begin
                    p_reg   <= PIW'(pg64);
                    off_reg <= off_reg & ((pfa_pkg::ADDR_W'(1) << s_eff) - 1'b1);
                end
                pfa_pkg::S_FR_CHK:
                begin
                    idx_reg <= EW'(quot);
                end
                pfa_pkg::S_RL_HEAD:
                begin
                    p_reg <= lh_cur;
                    if (sts.head_nil)
                    begin
                        st_reg <= pfa_pkg::ST_NOEMPTY;
                    end
                end
                pfa_pkg::S_RL_ADDR:
                begin
                    res_reg <= page_base;
                end
                pfa_pkg::S_FAIL:
                begin
                    st_reg  <= pfa_pkg::ST_NOPAGE;
                    res_reg <= '0;
                end
                pfa_pkg::S_RM_RD:
                begin
                    pv_reg <= r_prev;
                    nx_reg <= r_next;
                end
                pfa_pkg::S_IN_HEAD:
                begin
                    pv_reg <= lh_cur;
                end
                pfa_pkg::S_IN_RD:
                begin
                    nx_reg <= (r_next >= PAGES_C) ? pv_reg : r_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_addr_reg <= res_reg;
            out_st_reg   <= st_reg;
        end
    end

    assign result_address = out_addr_reg;
    assign status         = out_st_reg;

endmodule

@@ sv/pfa_ctrl.sv @@
// Controller: sequences each operation as steps on the datapath.
module pfa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    operation,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  pfa_pkg::sts_t sts,
    output pfa_pkg::cmd_t cmd
);

    pfa_pkg::state_t state_reg;
    pfa_pkg::state_t state_next;
    pfa_pkg::state_t ret_reg;
    pfa_pkg::state_t ret_next;
    logic            ov_reg;
    logic            ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfa_pkg::S_IDLE;
            ret_reg   <= pfa_pkg::S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        in_ready   = 1'b0;
        cmd.step   = state_reg;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        ov_next    = (ov_reg && out_ready) ? 1'b0 : ov_reg;
        case (state_reg)
            pfa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (operation)
                        pfa_pkg::OP_ALLOC:   state_next = pfa_pkg::S_AL_HEAD;
                        pfa_pkg::OP_FREE:    state_next = pfa_pkg::S_FR_SUB;
                        pfa_pkg::OP_RELEASE: state_next = pfa_pkg::S_RL_HEAD;
                        default:             state_next = pfa_pkg::S_DONE;
                    endcase
                end
            end
            pfa_pkg::S_AL_HEAD:
            begin
                state_next = sts.head_nil ? pfa_pkg::S_AL_DIV : pfa_pkg::S_SERVE;
            end
            pfa_pkg::S_AL_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = pfa_pkg::S_AL_CAP;
                end
            end
            pfa_pkg::S_AL_CAP:
            begin
                state_next = sts.cap_zero ? pfa_pkg::S_FAIL : pfa_pkg::S_AL_POOL;
            end
            pfa_pkg::S_AL_POOL:
            begin
                if (!sts.head_nil)
                begin
                    state_next = pfa_pkg::S_RM_RD;
                    ret_next   = pfa_pkg::S_AL_SETUP;
                end
                else if (sts.bump_left)
                begin
                    state_next = pfa_pkg::S_AL_SETUP;
                end
                else
                begin
                    state_next = pfa_pkg::S_FAIL;
                end
            end
            pfa_pkg::S_AL_SETUP:
            begin
                state_next = pfa_pkg::S_IN_HEAD;
                ret_next   = pfa_pkg::S_SERVE;
            end
            pfa_pkg::S_SERVE:
            begin
                if (sts.chain_ok)
                begin
                    state_next = pfa_pkg::S_LINK;
                end
                else if (sts.bump_ok)
                begin
                    state_next = pfa_pkg::S_USED;
                end
                else
                begin
                    state_next = pfa_pkg::S_FAIL;
                end
            end
            pfa_pkg::S_LINK:
            begin
                state_next = pfa_pkg::S_USED;
            end
            pfa_pkg::S_USED:
            begin
                if (sts.now_full)
                begin
                    state_next = pfa_pkg::S_RM_RD;
                    ret_next   = pfa_pkg::S_MUL;
                end
                else
                begin
                    state_next = pfa_pkg::S_MUL;
                end
            end
            pfa_pkg::S_MUL:
            begin
                state_next = pfa_pkg::S_ADDR;
            end
            pfa_pkg::S_ADDR:
            begin
                state_next = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_FR_SUB:
            begin
                state_next = pfa_pkg::S_FR_PAGE;
            end
            pfa_pkg::S_FR_PAGE:
            begin
                state_next = sts.out_range ? pfa_pkg::S_DONE : pfa_pkg::S_FR_CHK0;
            end
            pfa_pkg::S_FR_CHK0:
            begin
                state_next = sts.page_idle ? pfa_pkg::S_DONE : pfa_pkg::S_FR_DIV;
            end
            pfa_pkg::S_FR_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = pfa_pkg::S_FR_CHK;
                end
            end
            pfa_pkg::S_FR_CHK:
            begin
                state_next = sts.idx_bad ? pfa_pkg::S_DONE : pfa_pkg::S_FR_UPD;
            end
            pfa_pkg::S_FR_UPD:
            begin
                if (sts.last_elem && !sts.was_full)
                begin
                    state_next = pfa_pkg::S_RM_RD;
                    ret_next   = pfa_pkg::S_FR_EMPTY;
                end
                else if (sts.was_full)
                begin
                    state_next = pfa_pkg::S_IN_HEAD;
                    ret_next   = pfa_pkg::S_DONE;
                end
                else
                begin
                    state_next = pfa_pkg::S_DONE;
                end
            end
            pfa_pkg::S_FR_EMPTY:
            begin
                state_next = pfa_pkg::S_IN_HEAD;
                ret_next   = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_RL_HEAD:
            begin
                if (sts.head_nil)
                begin
                    state_next = pfa_pkg::S_DONE;
                end
                else
                begin
                    state_next = pfa_pkg::S_RM_RD;
                    ret_next   = pfa_pkg::S_RL_POOL;
                end
            end
            pfa_pkg::S_RL_POOL:
            begin
                state_next = pfa_pkg::S_IN_HEAD;
                ret_next   = pfa_pkg::S_RL_ADDR;
            end
            pfa_pkg::S_RL_ADDR:
            begin
                state_next = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_RM_RD:
            begin
                state_next = pfa_pkg::S_RM_PV;
            end
            pfa_pkg::S_RM_PV:
            begin
                state_next = pfa_pkg::S_RM_NX;
            end
            pfa_pkg::S_RM_NX:
            begin
                state_next = pfa_pkg::S_RM_CLR;
            end
            pfa_pkg::S_RM_CLR:
            begin
                state_next = ret_reg;
            end
            pfa_pkg::S_IN_HEAD:
            begin
                state_next = sts.head_nil ? ret_reg : pfa_pkg::S_IN_RD;
            end
            pfa_pkg::S_IN_RD:
            begin
                state_next = pfa_pkg::S_IN_P;
            end
            pfa_pkg::S_IN_P:
            begin
                state_next = pfa_pkg::S_IN_H;
            end
            pfa_pkg::S_IN_H:
            begin
                state_next = pfa_pkg::S_IN_N;
            end
            pfa_pkg::S_IN_N:
            begin
                state_next = ret_reg;
            end
            pfa_pkg::S_FAIL:
            begin
                state_next = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.load   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = pfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pfa_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && ov_reg) |-> out_ready)
        else $error("pending transaction overwritten");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != pfa_pkg::S_IDLE))
        else $error("accepted transaction not started");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("result not presented");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pfa_pkg::S_AL_DIV) && !sts.div_busy) |=>
        (state_reg == pfa_pkg::S_AL_CAP))
        else $error("divider wait not left");
`endif

endmodule

@@ sv/paged_fixed_size_element_allocator.sv @@
// Paged fixed-size element allocator top level.
// An allocation that sets up a page and a free both wait on the divider; an allocation
// from a usable page and a release do not.
// Throughput: one transaction at a time; the next is taken once a result is registered.
// Reset clears page table and list heads at once; element links are written before use.
module paged_fixed_size_element_allocator
#(
    parameter int PAGES          = 16,
    parameter int ELEMS_PER_PAGE = 256,
    parameter int SIZE_CLASSES   = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pfa_pkg::ADDR_W-1:0]      cfg_data,
    pfa_req_if.sink                         req,
    pfa_rsp_if.source                       rsp
);

    pfa_pkg::cmd_t cmd;
    pfa_pkg::sts_t sts;

    pfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .operation (req.operation),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfa_datapath
    #(
        .PAGES          (PAGES),
        .ELEMS_PER_PAGE (ELEMS_PER_PAGE),
        .SIZE_CLASSES   (SIZE_CLASSES)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (req.operation),
        .size_class     (req.size_class),
        .elem_size      (req.elem_size),
        .address        (req.address),
        .cmd            (cmd),
        .sts            (sts),
        .result_address (rsp.result_address),
        .status         (rsp.status)
    );

endmodule
